/* hw/rtl/apu_pkg.sv */
// apu_pkg: shared types and constants of the Adam parameter update core.
// No dependencies; imported by every module of the block but apu_ram.
package apu_pkg;

    // register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_LEARNING_RATE = 2'd0;
    localparam logic [1:0] REG_BETA_ONE      = 2'd1;
    localparam logic [1:0] REG_BETA_TWO      = 2'd2;

    localparam logic [23:0] LR_RESET  = 24'd16777;
    localparam logic [15:0] B1_RESET  = 16'd58982;
    localparam logic [15:0] B2_RESET  = 16'd65470;
    localparam logic [31:0] POWER_ONE = 32'hFFFF_FFFF;

    // epsilon of 1e-7 in Q8.24, and the clip on the update magnitude
    localparam logic [32:0] EPS_Q24 = 33'd2;
    localparam logic [33:0] MAG_CAP = 34'h2_0000_0000;

    typedef struct packed {
        logic [23:0] learning_rate;
        logic [15:0] beta_one;
        logic [15:0] beta_two;
    } cfg_t;

    typedef struct packed {
        logic        done;
        logic [31:0] rate;
    } step_stat_t;

    // one accepted parameter with the rate snapshot taken at acceptance
    typedef struct packed {
        logic [15:0]        idx;
        logic signed [31:0] param;
        logic signed [31:0] grad;
        logic [31:0]        rate;
    } item_t;

    // updated moments handed from the moment stage to the quotient pipeline
    typedef struct packed {
        logic [15:0]        idx;
        logic signed [31:0] param;
        logic signed [31:0] m;
        logic [47:0]        v;
        logic [31:0]        rate;
    } mom_t;

    typedef struct packed {
        logic [15:0]        idx;
        logic signed [31:0] new_param;
        logic               sat;
    } result_t;

    // one moment memory word
    typedef struct packed {
        logic        touched;
        logic [47:0] v;
        logic [31:0] m;
    } entry_t;

endpackage

/* hw/rtl/apu_ram.sv */
// apu_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module apu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/apu_step.sv */
// apu_step: step sequencer; advances the beta powers and the bias-corrected rate
// with a serial square root and a serial restoring divider. Depends on apu_pkg.
module apu_step (
    input  logic              clk,
    input  logic              rst_n,
    input  apu_pkg::cfg_t     cfg,
    input  logic              req,
    input  logic              take,
    output apu_pkg::step_stat_t stat
);
    import apu_pkg::*;

    localparam logic [5:0] ROOT_LAST = 6'd24;
    localparam logic [5:0] DIV_LAST  = 6'd56;

    typedef enum logic [2:0] {
        ST_IDLE, ST_POW, ST_PREP, ST_ROOT, ST_SCALE, ST_DIV, ST_FIN, ST_DONE
    } state_t;

    state_t      state_reg, state_next;
    logic [31:0] p1_reg, p1_next, p2_reg, p2_next;
    logic [32:0] om1_reg, om1_next;
    logic [49:0] x_reg, x_next;
    logic [26:0] r_reg, r_next;
    logic [24:0] root_reg, root_next;
    logic [56:0] num_reg, num_next;
    logic [32:0] rem_reg, rem_next;
    logic [56:0] quo_reg, quo_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [31:0] rate_reg, rate_next;

    logic [47:0] p1_prod, p2_prod;
    logic [28:0] rs, rt;
    logic [33:0] dt;
    logic [48:0] scale_prod;
    logic [32:0] om2;

    assign p1_prod    = 48'(p1_reg) * 48'(cfg.beta_one);
    assign p2_prod    = 48'(p2_reg) * 48'(cfg.beta_two);
    assign om2        = 33'h1_0000_0000 - 33'(p2_reg);
    assign rs         = {r_reg, x_reg[49:48]};
    assign rt         = {2'b00, root_reg, 2'b01};
    assign dt         = {rem_reg, num_reg[56]};
    assign scale_prod = 49'(cfg.learning_rate) * 49'(root_reg);

    always_comb
    begin
        state_next = state_reg;
        p1_next    = p1_reg;
        p2_next    = p2_reg;
        om1_next   = om1_reg;
        x_next     = x_reg;
        r_next     = r_reg;
        root_next  = root_reg;
        num_next   = num_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        cnt_next   = cnt_reg;
        rate_next  = rate_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req)
                begin
                    state_next = ST_POW;
                end
            end
            ST_POW:
            begin
                p1_next    = p1_prod[47:16];
                p2_next    = p2_prod[47:16];
                state_next = ST_PREP;
            end
            ST_PREP:
            begin
                om1_next   = 33'h1_0000_0000 - 33'(p1_reg);
                x_next     = {1'b0, om2, 16'd0};
                r_next     = '0;
                root_next  = '0;
                cnt_next   = '0;
                state_next = ST_ROOT;
            end
            ST_ROOT:
            begin
                if (rs >= rt)
                begin
                    r_next    = 27'(rs - rt);
                    root_next = {root_reg[23:0], 1'b1};
                end
                else
                begin
                    r_next    = rs[26:0];
                    root_next = {root_reg[23:0], 1'b0};
                end
                x_next   = {x_reg[47:0], 2'b00};
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == ROOT_LAST)
                begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                num_next   = {scale_prod, 8'd0};
                rem_next   = '0;
                quo_next   = '0;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (dt >= {1'b0, om1_reg})
                begin
                    rem_next = 33'(dt - {1'b0, om1_reg});
                    quo_next = {quo_reg[55:0], 1'b1};
                end
                else
                begin
                    rem_next = dt[32:0];
                    quo_next = {quo_reg[55:0], 1'b0};
                end
                num_next = {num_reg[55:0], 1'b0};
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                rate_next  = (|quo_reg[56:32]) ? 32'hFFFF_FFFF : quo_reg[31:0];
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            p1_reg    <= POWER_ONE;
            p2_reg    <= POWER_ONE;
            rate_reg  <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            p1_reg    <= p1_next;
            p2_reg    <= p2_next;
            rate_reg  <= rate_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        om1_reg  <= om1_next;
        x_reg    <= x_next;
        r_reg    <= r_next;
        root_reg <= root_next;
        num_reg  <= num_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
    end

    assign stat.done = (state_reg == ST_DONE);
    assign stat.rate = rate_reg;

endmodule

/* hw/rtl/apu_moment.sv */
// apu_moment: slot mapping, moment memory read-modify-write with forwarding,
// and the clearing pass after reset. Depends on apu_pkg and apu_ram.
module apu_moment #(
    parameter int PARAM_DEPTH = 65536
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           adv,
    input  logic           in_valid,
    input  apu_pkg::item_t in_item,
    input  apu_pkg::cfg_t  cfg,
    output logic           busy,
    output logic           out_valid,
    output apu_pkg::mom_t  out_mom
);
    import apu_pkg::*;

    localparam int AW = (PARAM_DEPTH > 1) ? $clog2(PARAM_DEPTH) : 1;
    localparam logic [32:0]   RECIP     = 33'((64'd1 << 32) / PARAM_DEPTH);
    localparam logic [41:0]   DEPTH_C   = 42'(PARAM_DEPTH);
    localparam logic [AW-1:0] LAST_SLOT = AW'(PARAM_DEPTH - 1);
    localparam int EW = $bits(entry_t);

    // stage 0: quotient estimate for the slot, gradient magnitude
    logic        s0_valid_reg;
    item_t       s0_item_reg;
    logic [48:0] s0_qprod;
    logic [31:0] s0_ag;
    assign s0_qprod = 49'(s0_item_reg.idx) * 49'(RECIP);
    assign s0_ag    = s0_item_reg.grad[31] ? (~s0_item_reg.grad + 32'd1) : s0_item_reg.grad;

    // stage 1
    logic        s1_valid_reg;
    item_t       s1_item_reg;
    logic [16:0] s1_qe_reg;
    logic [31:0] s1_ag_reg;
    logic [41:0] s1_qd;
    logic [63:0] s1_sq;
    assign s1_qd = 42'(s1_qe_reg) * DEPTH_C;
    assign s1_sq = 64'(s1_ag_reg) * 64'(s1_ag_reg);

    // stage 2
    logic        s2_valid_reg;
    item_t       s2_item_reg;
    logic [41:0] s2_qd_reg;
    logic [47:0] s2_g2_reg;
    logic [41:0] s2_rem, s2_fix;
    logic [16:0] s2_k2;
    logic [63:0] s2_gt;
    assign s2_rem = 42'(s2_item_reg.idx) - s2_qd_reg;
    assign s2_fix = (s2_rem >= DEPTH_C) ? (s2_rem - DEPTH_C) : s2_rem;
    assign s2_k2  = 17'h1_0000 - 17'(cfg.beta_two);
    assign s2_gt  = 64'(s2_g2_reg) * 64'(s2_k2);

    // stage 3: memory read
    logic          s3_valid_reg;
    item_t         s3_item_reg;
    logic [AW-1:0] s3_slot_reg;
    logic [63:0]   s3_gt_reg;

    // stage 4: moment update and write back
    logic          s4_valid_reg;
    item_t         s4_item_reg;
    logic [AW-1:0] s4_slot_reg;
    logic [63:0]   s4_gt_reg;
    logic [EW-1:0] rdata;

    // last write, forwarded over a read taken at the same edge
    logic          last_valid_reg;
    logic [AW-1:0] last_slot_reg;
    entry_t        last_entry_reg;

    logic               clr_busy_reg;
    logic [AW-1:0]      clr_cnt_reg;

    entry_t             cur;
    logic signed [31:0] m_old;
    logic [47:0]        v_old;
    logic signed [32:0] diff;
    logic [16:0]        k1;
    logic signed [49:0] mprod, msum;
    logic [64:0]        vprod;
    entry_t             new_entry;

    assign cur   = (last_valid_reg && (last_slot_reg == s4_slot_reg))
                   ? last_entry_reg : entry_t'(rdata);
    assign m_old = cur.touched ? $signed(cur.m) : 32'sd0;
    assign v_old = cur.touched ? cur.v : 48'd0;
    assign diff  = $signed({s4_item_reg.grad[31], s4_item_reg.grad}) - $signed({m_old[31], m_old});
    assign k1    = 17'h1_0000 - 17'(cfg.beta_one);
    assign mprod = diff * $signed({1'b0, k1});
    assign msum  = $signed({{18{m_old[31]}}, m_old}) + (mprod >>> 16);
    assign vprod = 65'(v_old) * 65'(cfg.beta_two) + 65'(s4_gt_reg);

    assign new_entry.touched = 1'b1;
    assign new_entry.v       = vprod[63:16];
    assign new_entry.m       = msum[31:0];

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [EW-1:0] ram_wdata;
    assign ram_we    = clr_busy_reg | (adv & s4_valid_reg);
    assign ram_waddr = clr_busy_reg ? clr_cnt_reg : s4_slot_reg;
    assign ram_wdata = clr_busy_reg ? '0 : EW'(new_entry);

    apu_ram #(
        .WIDTH(EW),
        .DEPTH(PARAM_DEPTH)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (adv & s3_valid_reg),
        .raddr(s3_slot_reg),
        .rdata(rdata)
    );

    logic  s5_valid_reg;
    mom_t  s5_mom_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg   <= 1'b0;
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            s3_valid_reg   <= 1'b0;
            s4_valid_reg   <= 1'b0;
            s5_valid_reg   <= 1'b0;
            last_valid_reg <= 1'b0;
            clr_busy_reg   <= 1'b1;
            clr_cnt_reg    <= '0;
        end
        else
        begin
            if (clr_busy_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == LAST_SLOT)
                begin
                    clr_busy_reg <= 1'b0;
                end
            end
            if (adv)
            begin
                s0_valid_reg <= in_valid;
                s1_valid_reg <= s0_valid_reg;
                s2_valid_reg <= s1_valid_reg;
                s3_valid_reg <= s2_valid_reg;
                s4_valid_reg <= s3_valid_reg;
                s5_valid_reg <= s4_valid_reg;
                if (s4_valid_reg)
                begin
                    last_valid_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_item_reg    <= in_item;
            s1_item_reg    <= s0_item_reg;
            s1_qe_reg      <= s0_qprod[48:32];
            s1_ag_reg      <= s0_ag;
            s2_item_reg    <= s1_item_reg;
            s2_qd_reg      <= s1_qd;
            s2_g2_reg      <= s1_sq[63:16];
            s3_item_reg    <= s2_item_reg;
            s3_slot_reg    <= s2_fix[AW-1:0];
            s3_gt_reg      <= s2_gt;
            s4_item_reg    <= s3_item_reg;
            s4_slot_reg    <= s3_slot_reg;
            s4_gt_reg      <= s3_gt_reg;
            if (s4_valid_reg)
            begin
                last_slot_reg  <= s4_slot_reg;
                last_entry_reg <= new_entry;
            end
            s5_mom_reg.idx   <= s4_item_reg.idx;
            s5_mom_reg.param <= s4_item_reg.param;
            s5_mom_reg.m     <= $signed(new_entry.m);
            s5_mom_reg.v     <= new_entry.v;
            s5_mom_reg.rate  <= s4_item_reg.rate;
        end
    end

    assign busy      = clr_busy_reg;
    assign out_valid = s5_valid_reg;
    assign out_mom   = s5_mom_reg;

endmodule

/* hw/rtl/apu_quot.sv */
// apu_quot: pipelined square root of v and pipelined divide of rate*|m|,
// then the clipped parameter update. Depends on apu_pkg.
module apu_quot (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  logic             in_valid,
    input  apu_pkg::mom_t    in_mom,
    output logic             out_valid,
    output apu_pkg::result_t out_res
);
    import apu_pkg::*;

    localparam int SQ_N = 16;   // two root bits per stage
    localparam int DV_N = 18;   // two quotient bits per stage

    typedef struct packed {
        logic [15:0]        idx;
        logic signed [31:0] param;
        logic               neg;
    } pl_t;

    typedef struct packed {
        logic [33:0] r;
        logic [31:0] q;
    } sq_t;

    typedef struct packed {
        logic [32:0] rem;
        logic [35:0] q;
    } dv_t;

    function automatic sq_t sq_step(sq_t s, logic [1:0] b);
        logic [35:0] rs;
        logic [35:0] t;
        sq_t         o;
        rs = {s.r, b};
        t  = {2'b00, s.q, 2'b01};
        if (rs >= t)
        begin
            o.r = 34'(rs - t);
            o.q = {s.q[30:0], 1'b1};
        end
        else
        begin
            o.r = rs[33:0];
            o.q = {s.q[30:0], 1'b0};
        end
        return o;
    endfunction

    function automatic dv_t dv_step(dv_t s, logic b, logic [32:0] d);
        logic [33:0] t;
        dv_t         o;
        t = {s.rem, b};
        if (t >= {1'b0, d})
        begin
            o.rem = 33'(t - {1'b0, d});
            o.q   = {s.q[34:0], 1'b1};
        end
        else
        begin
            o.rem = t[32:0];
            o.q   = {s.q[34:0], 1'b0};
        end
        return o;
    endfunction

    // entry: |m| and the numerator product
    logic [31:0] am;
    logic [63:0] num0;
    assign am   = in_mom.m[31] ? (~in_mom.m + 32'd1) : in_mom.m;
    assign num0 = 64'(in_mom.rate) * 64'(am);

    logic        sq_valid_reg [0:SQ_N];
    sq_t         sq_reg       [0:SQ_N];
    logic [63:0] sq_x_reg     [0:SQ_N];
    logic [63:0] sq_num_reg   [0:SQ_N];
    pl_t         sq_pl_reg    [0:SQ_N];
    sq_t         sq_next      [0:SQ_N-1];

    always_comb
    begin
        for (int k = 0; k < SQ_N; k++)
        begin
            sq_next[k] = sq_step(sq_step(sq_reg[k], sq_x_reg[k][63:62]), sq_x_reg[k][61:60]);
        end
    end

    // divide setup from the root
    logic [32:0] d0;
    logic [27:0] rem0;
    logic        ovf0;
    assign d0   = 33'(sq_reg[SQ_N].q) + EPS_Q24;
    assign rem0 = sq_num_reg[SQ_N][63:36];
    assign ovf0 = (33'(rem0) >= d0);

    logic        dv_valid_reg [0:DV_N];
    dv_t         dv_reg       [0:DV_N];
    logic [35:0] dv_n_reg     [0:DV_N];
    logic [32:0] dv_d_reg     [0:DV_N];
    logic        dv_ovf_reg   [0:DV_N];
    pl_t         dv_pl_reg    [0:DV_N];
    dv_t         dv_next      [0:DV_N-1];

    always_comb
    begin
        for (int k = 0; k < DV_N; k++)
        begin
            dv_next[k] = dv_step(dv_step(dv_reg[k], dv_n_reg[k][35], dv_d_reg[k]),
                                 dv_n_reg[k][34], dv_d_reg[k]);
        end
    end

    // final clip of the magnitude and the saturating update
    logic [33:0]        mag;
    logic signed [35:0] np;
    logic               sat;
    pl_t                fin_pl;
    assign fin_pl = dv_pl_reg[DV_N];
    assign mag = (dv_ovf_reg[DV_N] || (dv_reg[DV_N].q > 36'(MAG_CAP)))
                 ? MAG_CAP : dv_reg[DV_N].q[33:0];
    assign np  = fin_pl.neg
                 ? ($signed({{4{fin_pl.param[31]}}, fin_pl.param}) + $signed({2'b00, mag}))
                 : ($signed({{4{fin_pl.param[31]}}, fin_pl.param}) - $signed({2'b00, mag}));
    assign sat = (np > 36'sd2147483647) || (np < -36'sd2147483648);

    logic    out_valid_reg;
    result_t out_res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= SQ_N; k++)
            begin
                sq_valid_reg[k] <= 1'b0;
            end
            for (int k = 0; k <= DV_N; k++)
            begin
                dv_valid_reg[k] <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            sq_valid_reg[0] <= in_valid;
            for (int k = 0; k < SQ_N; k++)
            begin
                sq_valid_reg[k+1] <= sq_valid_reg[k];
            end
            dv_valid_reg[0] <= sq_valid_reg[SQ_N];
            for (int k = 0; k < DV_N; k++)
            begin
                dv_valid_reg[k+1] <= dv_valid_reg[k];
            end
            out_valid_reg <= dv_valid_reg[DV_N];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_reg[0]       <= '0;
            sq_x_reg[0]     <= {in_mom.v, 16'd0};
            sq_num_reg[0]   <= num0;
            sq_pl_reg[0]    <= '{idx: in_mom.idx, param: in_mom.param, neg: in_mom.m[31]};
            for (int k = 0; k < SQ_N; k++)
            begin
                sq_reg[k+1]     <= sq_next[k];
                sq_x_reg[k+1]   <= {sq_x_reg[k][59:0], 4'd0};
                sq_num_reg[k+1] <= sq_num_reg[k];
                sq_pl_reg[k+1]  <= sq_pl_reg[k];
            end
            dv_reg[0].rem <= ovf0 ? 33'd0 : 33'(rem0);
            dv_reg[0].q   <= '0;
            dv_n_reg[0]   <= sq_num_reg[SQ_N][35:0];
            dv_d_reg[0]   <= d0;
            dv_ovf_reg[0] <= ovf0;
            dv_pl_reg[0]  <= sq_pl_reg[SQ_N];
            for (int k = 0; k < DV_N; k++)
            begin
                dv_reg[k+1]     <= dv_next[k];
                dv_n_reg[k+1]   <= {dv_n_reg[k][33:0], 2'b00};
                dv_d_reg[k+1]   <= dv_d_reg[k];
                dv_ovf_reg[k+1] <= dv_ovf_reg[k];
                dv_pl_reg[k+1]  <= dv_pl_reg[k];
            end
            out_res_reg.idx       <= fin_pl.idx;
            out_res_reg.new_param <= sat ? (np[35] ? 32'sh8000_0000 : 32'sh7FFF_FFFF)
                                         : np[31:0];
            out_res_reg.sat       <= sat;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

endmodule

/* hw/rtl/adam_parameter_update_core.sv */
// adam_parameter_update_core: top level of the Adam optimizer update engine.
// Depends on apu_pkg, apu_step, apu_moment, apu_quot (and apu_ram below them).
//
// One parameter transaction enters per clock unless held off: flat index,
// Q8.24 value and gradient in s_tdata, and a new-step flag in s_tuser. Every
// transaction gives exactly one result transaction, in order: the index, the
// updated Q8.24 value and a saturation flag. The first and second moments of
// each slot live in one PARAM_DEPTH-deep synchronous RAM; a read-modify-write
// stage updates them with forwarding, so back-to-back hits on the same index
// are safe. Indexes wrap modulo PARAM_DEPTH. Sustained rate is one transaction
// per cycle while the output queue has room, set by the single moment RAM port
// pair; the sqrt and divide units are fully pipelined. A transaction with the
// new-step flag waits in front of s_tready while the step sequencer advances
// the beta powers and computes the bias-corrected rate with its serial root and
// serial divider. After reset a clearing pass marks every slot untouched; no
// input is taken during it, configuration writes are. A 2-entry output queue
// decouples the pipeline from m_tready; the whole pipeline holds when the queue
// is full. Configuration is APB: 0x0 learning rate (Q0.24), 0x4 beta one, 0x8
// beta two (Q0.16); write only while idle.
module adam_parameter_update_core #(
    parameter int PARAM_DEPTH = 65536
) (
    input  logic        clk,
    input  logic        rst_n,
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // element_index[15:0], param_value[47:16], gradient[79:48]
    input  logic [0:0]  s_tuser,   // new_step[0]
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // result_index[15:0], new_param[47:16]
    output logic [0:0]  m_tuser    // saturated[0]
);
    import apu_pkg::*;

    // configuration registers
    cfg_t cfg_reg;
    logic cfg_wr;
    assign cfg_wr = psel & penable & pwrite & pready;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.learning_rate <= LR_RESET;
            cfg_reg.beta_one      <= B1_RESET;
            cfg_reg.beta_two      <= B2_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_LEARNING_RATE: cfg_reg.learning_rate <= pwdata[23:0];
                REG_BETA_ONE:      cfg_reg.beta_one      <= pwdata[15:0];
                REG_BETA_TWO:      cfg_reg.beta_two      <= pwdata[15:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_LEARNING_RATE: prdata = {8'd0, cfg_reg.learning_rate};
            REG_BETA_ONE:      prdata = {16'd0, cfg_reg.beta_one};
            REG_BETA_TWO:      prdata = {16'd0, cfg_reg.beta_two};
            default:           prdata = 32'd0;
        endcase
    end

    // output queue, two entries; the pipeline advances while it has room
    result_t     fifo_reg [0:1];
    logic        wr_ptr_reg, rd_ptr_reg;
    logic [1:0]  cnt_reg;
    logic        adv;
    logic        push, pop;
    logic        q_valid;
    result_t     q_res;

    assign adv  = (cnt_reg != 2'd2);
    assign push = adv & q_valid;
    assign pop  = m_tvalid & m_tready;

    // step sequencer; a new-step transaction is held off until its rate is ready
    step_stat_t step_stat;
    logic       busy;
    logic       accept;

    assign s_tready = adv & ~busy & (~s_tuser[0] | step_stat.done);
    assign accept   = s_tvalid & s_tready;

    apu_step u_step (
        .clk  (clk),
        .rst_n(rst_n),
        .cfg  (cfg_reg),
        .req  (s_tvalid & s_tuser[0]),
        .take (accept & s_tuser[0]),
        .stat (step_stat)
    );

    item_t in_item;
    assign in_item.idx   = s_tdata[15:0];
    assign in_item.param = $signed(s_tdata[47:16]);
    assign in_item.grad  = $signed(s_tdata[79:48]);
    assign in_item.rate  = step_stat.rate;

    logic mom_valid;
    mom_t mom;

    apu_moment #(
        .PARAM_DEPTH(PARAM_DEPTH)
    ) u_moment (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (accept),
        .in_item  (in_item),
        .cfg      (cfg_reg),
        .busy     (busy),
        .out_valid(mom_valid),
        .out_mom  (mom)
    );

    apu_quot u_quot (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (mom_valid),
        .in_mom   (mom),
        .out_valid(q_valid),
        .out_res  (q_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= q_res;
        end
    end

    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tdata  = {fifo_reg[rd_ptr_reg].new_param, fifo_reg[rd_ptr_reg].idx};
    assign m_tuser  = fifo_reg[rd_ptr_reg].sat;

endmodule
